### hdl/b2da_pkg.sv
package b2da_pkg;

    localparam int NUMBER_W = 32;
    localparam int COUNT_W  = 4;
    localparam int CHAR_W   = 6;
    localparam int DIGIT_W  = 4;

    localparam int MAX_DIGITS_DEFAULT = 10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x.
    localparam logic [NUMBER_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                  RECIP_SHIFT = 35;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PEEL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic peel;
        logic emit_step;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic peel_last;
        logic emit_last;
    } status_t;

endpackage

### hdl/b2da_in_if.sv
interface b2da_in_if;

    logic                           valid;
    logic                           ready;
    logic [b2da_pkg::NUMBER_W-1:0]  number;
    logic [b2da_pkg::COUNT_W-1:0]   digit_count;

    modport source (output valid, output number, output digit_count, input ready);
    modport sink   (input valid, input number, input digit_count, output ready);

endinterface

### hdl/b2da_out_if.sv
interface b2da_out_if;

    logic                         valid;
    logic                         ready;
    logic [b2da_pkg::CHAR_W-1:0]  digit_char;
    logic                         last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);

endinterface

### hdl/b2da_ctrl.sv
module b2da_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output b2da_pkg::cmd_t     cmd,
    input  b2da_pkg::status_t  status
);

    b2da_pkg::state_t state_reg;
    b2da_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= b2da_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd.load      = 1'b0;
        cmd.peel      = 1'b0;
        cmd.emit_step = 1'b0;

        unique case (state_reg)
            b2da_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    // A count of zero produces no digits at all.
                    if (!status.count_zero)
                    begin
                        state_next = b2da_pkg::ST_PEEL;
                    end
                end
            end
            b2da_pkg::ST_PEEL:
            begin
                cmd.peel = 1'b1;
                if (status.peel_last)
                begin
                    state_next = b2da_pkg::ST_EMIT;
                end
            end
            b2da_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.emit_step = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = b2da_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = b2da_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/b2da_dp.sv
module b2da_dp #(
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  b2da_pkg::cmd_t                  cmd,
    output b2da_pkg::status_t               status,
    input  logic [b2da_pkg::NUMBER_W-1:0]   number,
    input  logic [b2da_pkg::COUNT_W-1:0]    digit_count,
    output logic [b2da_pkg::CHAR_W-1:0]     digit_char,
    output logic                            last_digit
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [b2da_pkg::COUNT_W-1:0] COUNT_MAX = b2da_pkg::COUNT_W'(MAX_DIGITS);

    logic [b2da_pkg::NUMBER_W-1:0]  value_reg;
    logic [b2da_pkg::NUMBER_W-1:0]  value_next;
    logic [b2da_pkg::COUNT_W-1:0]   count_reg;
    logic [b2da_pkg::COUNT_W-1:0]   count_next;
    logic [b2da_pkg::COUNT_W-1:0]   idx_reg;
    logic [b2da_pkg::COUNT_W-1:0]   idx_next;
    logic [b2da_pkg::DIGIT_W-1:0]   digits_reg [MAX_DIGITS];
    logic [b2da_pkg::DIGIT_W-1:0]   digits_next [MAX_DIGITS];

    logic [b2da_pkg::COUNT_W-1:0]     count_sat;
    logic [2*b2da_pkg::NUMBER_W-1:0]  product;
    logic [b2da_pkg::NUMBER_W-1:0]    quotient;
    logic [b2da_pkg::NUMBER_W-1:0]    times_ten;
    logic [b2da_pkg::NUMBER_W-1:0]    remainder;
    logic [IDX_W-1:0]                 idx;

    assign count_sat = (digit_count > COUNT_MAX) ? COUNT_MAX : digit_count;
    assign idx       = idx_reg[IDX_W-1:0];

    // One digit per cycle: quotient by reciprocal multiply, remainder by shift-add.
    assign product   = {{b2da_pkg::NUMBER_W{1'b0}}, value_reg}
                     * {{b2da_pkg::NUMBER_W{1'b0}}, b2da_pkg::RECIP_10};
    assign quotient  = b2da_pkg::NUMBER_W'(product >> b2da_pkg::RECIP_SHIFT);
    assign times_ten = (quotient << 3) + (quotient << 1);
    assign remainder = value_reg - times_ten;

    assign status.count_zero = (digit_count == '0);
    assign status.peel_last  = (idx_reg == count_reg - 1'b1);
    assign status.emit_last  = (idx_reg == '0);

    assign digit_char = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(digits_reg[idx]);
    assign last_digit = (idx_reg == '0);

    always_comb
    begin
        value_next  = value_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        digits_next = digits_reg;

        if (cmd.load)
        begin
            value_next = number;
            count_next = count_sat;
            idx_next   = '0;
        end
        else if (cmd.peel)
        begin
            digits_next[idx] = remainder[b2da_pkg::DIGIT_W-1:0];
            value_next       = quotient;
            // The index stops on the most significant digit, where emission starts.
            if (idx_reg != count_reg - 1'b1)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        else if (cmd.emit_step)
        begin
            idx_next = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        digits_reg <= digits_next;
    end

endmodule

### hdl/binary_to_decimal_ascii.sv
// After a number's transfer the divide-by-ten unit peels N digits (N = saturated count), one digit
// a cycle, then one digit leaves per output transfer; a new number is taken only once the last
// digit has left.
// A number with a count of zero yields no digits.
// Reset (rst_n, asynchronous, active low) returns the controller to idle, ready for a number.
module binary_to_decimal_ascii #(
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEFAULT
) (
    input logic         clk,
    input logic         rst_n,
    b2da_in_if.sink     bin,
    b2da_out_if.source  dec
);

    b2da_pkg::cmd_t    cmd;
    b2da_pkg::status_t status;

    b2da_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bin.valid),
        .in_ready  (bin.ready),
        .out_valid (dec.valid),
        .out_ready (dec.ready),
        .cmd       (cmd),
        .status    (status)
    );

    b2da_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .number      (bin.number),
        .digit_count (bin.digit_count),
        .digit_char  (dec.digit_char),
        .last_digit  (dec.last_digit)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(bin.ready && dec.valid))
        else $error("input accepted while digits are still pending");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        dec.valid |-> (dec.digit_char >= b2da_pkg::ASCII_ZERO)
                   && (dec.digit_char <= b2da_pkg::ASCII_ZERO + 6'd9))
        else $error("digit character outside '0' to '9'");

    a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (dec.valid && dec.ready && dec.last_digit) |=> bin.ready)
        else $error("block not idle after the last digit transfer");

    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (bin.valid && bin.ready && (bin.digit_count != '0)) |=> !bin.ready)
        else $error("block idle right after accepting a nonzero count");

endmodule
